// ===== hdl/qtls_pkg.sv =====
// Shared types and constants for the Q-table learn and select engine.
`timescale 1ns / 1ps

package qtls_pkg;

    // Default sizes
    localparam int NUM_STATES_DEF  = 1024;
    localparam int MAX_ACTIONS_DEF = 32;
    localparam int Q_WIDTH_DEF     = 32;

    // Field widths fixed by the interface
    localparam int OP_W    = 2;
    localparam int SIDX_W  = 10;
    localparam int AIDX_W  = 5;
    localparam int DATA_W  = 32;
    localparam int DRAW_W  = 16;
    localparam int COUNT_W = 6;
    localparam int FRAC_W  = 17;

    localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;

    // Register reset values
    localparam logic [COUNT_W-1:0] ACTION_COUNT_RST = 6'd32;
    localparam logic [FRAC_W-1:0]  LEARN_RATE_RST   = 17'd6554;
    localparam logic [FRAC_W-1:0]  DISCOUNT_RST     = 17'd58982;
    localparam logic [FRAC_W-1:0]  EXPLORE_RATE_RST = 17'd6554;

    // Register indexes (byte address / 4)
    localparam logic [1:0] REG_ACTION_COUNT = 2'd0;
    localparam logic [1:0] REG_LEARN_RATE   = 2'd1;
    localparam logic [1:0] REG_DISCOUNT     = 2'd2;
    localparam logic [1:0] REG_EXPLORE_RATE = 2'd3;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE  = 2'd0,
        OP_READ   = 2'd1,
        OP_LEARN  = 2'd2,
        OP_SELECT = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WRAP,
        S_WR,
        S_RDRD,
        S_RDCAP,
        S_SCAN,
        S_CURRD,
        S_CUR,
        S_MUL,
        S_SUM,
        S_TGT,
        S_DIFF,
        S_UPD,
        S_DIV,
        S_PICK,
        S_DONE
    } t_state;

endpackage

// ===== hdl/q_table_learn_select_engine.sv =====
// Q-table learn and select engine: table memory, sequencer and APB registers.
`timescale 1ns / 1ps

//  channel | direction | handshake                  | payload
//  in      | input     | i_in_valid / o_in_ready    | i_op .. i_pick_draw
//  out     | output    | o_out_valid / i_out_ready  | o_chosen_action, o_q_value, o_saturated
//  cfg     | input     | psel, penable, pwrite      | paddr, pwdata, prdata, pready
//
//  One item at a time. Every item first passes the state index wrap (a
//  restoring reduction by the table height), then: write, read, learn (one
//  table read per column, then the shared 18x17 and 16x17 multiply pair twice),
//  greedy select (a scan of the columns in use), explore select (bit-serial
//  remainder, then a walk over the columns to the picked action).
//  Reset is synchronous; the table memory is not cleared.
//  A result waiting on i_out_ready holds the sequencer in its last cycle;
//  the output register lets the next item be taken meanwhile.
module q_table_learn_select_engine
    import qtls_pkg::*;
#(
    parameter int NUM_STATES  = NUM_STATES_DEF,
    parameter int MAX_ACTIONS = MAX_ACTIONS_DEF,
    parameter int Q_WIDTH     = Q_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,

    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [OP_W-1:0]          i_op,
    input  logic [SIDX_W-1:0]        i_state_index,
    input  logic [SIDX_W-1:0]        i_next_state_index,
    input  logic [AIDX_W-1:0]        i_action_index,
    input  logic signed [DATA_W-1:0] i_reward,
    input  logic signed [DATA_W-1:0] i_entry_value,
    input  logic [DATA_W-1:0]        i_valid_mask,
    input  logic [DRAW_W-1:0]        i_explore_draw,
    input  logic [DRAW_W-1:0]        i_pick_draw,

    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [AIDX_W-1:0]        o_chosen_action,
    output logic signed [DATA_W-1:0] o_q_value,
    output logic                     o_saturated,

    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [3:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    localparam int AW    = $clog2(MAX_ACTIONS);
    localparam int CW    = $clog2(MAX_ACTIONS + 1);
    localparam int SW    = $clog2(NUM_STATES);
    localparam int ADW   = SW + AW;
    localparam int DEPTH = NUM_STATES << AW;
    localparam int QW    = Q_WIDTH;
    localparam int DW    = ((QW > DATA_W) ? QW : DATA_W) + 2;
    localparam int UW    = DW + 1;

    localparam logic [3:0] WRAP_START = (NUM_STATES < (1 << SIDX_W)) ? 4'd9 : 4'd0;

    localparam logic signed [UW-1:0] Q_HI = {{(UW-QW+1){1'b0}}, {(QW-1){1'b1}}};
    localparam logic signed [UW-1:0] Q_LO = {{(UW-QW+1){1'b1}}, {(QW-1){1'b0}}};

    function automatic logic [AW-1:0] wrap_act(input logic [AIDX_W-1:0] a);
        logic [9:0] r;
        r = {5'b0, a};
        for (int k = 4; k >= 0; k--) begin
            if (r >= 10'(MAX_ACTIONS << k)) begin
                r = r - 10'(MAX_ACTIONS << k);
            end
        end
        return AW'(r);
    endfunction

    function automatic logic [FRAC_W-1:0] clamp_frac(input logic [FRAC_W-1:0] f);
        return f[FRAC_W-1] ? FRAC_ONE : f;
    endfunction

    function automatic logic [DATA_W-1:0] to_out(input logic signed [QW-1:0] v);
        return DATA_W'(v);
    endfunction

    function automatic logic [QW-1:0] clip_q(input logic signed [UW-1:0] v);
        logic [QW-1:0] r;
        if (v > Q_HI) begin
            r = Q_HI[QW-1:0];
        end else if (v < Q_LO) begin
            r = Q_LO[QW-1:0];
        end else begin
            r = v[QW-1:0];
        end
        return r;
    endfunction

    // Configuration registers
    logic [COUNT_W-1:0] r_action_count;
    logic [FRAC_W-1:0]  r_learn_rate;
    logic [FRAC_W-1:0]  r_discount;
    logic [FRAC_W-1:0]  r_explore_rate;
    logic               cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_action_count <= ACTION_COUNT_RST;
            r_learn_rate   <= LEARN_RATE_RST;
            r_discount     <= DISCOUNT_RST;
            r_explore_rate <= EXPLORE_RATE_RST;
        end else if (cfg_we) begin
            case (paddr[3:2])
                REG_ACTION_COUNT: r_action_count <= pwdata[COUNT_W-1:0];
                REG_LEARN_RATE:   r_learn_rate   <= pwdata[FRAC_W-1:0];
                REG_DISCOUNT:     r_discount     <= pwdata[FRAC_W-1:0];
                REG_EXPLORE_RATE: r_explore_rate <= pwdata[FRAC_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_ACTION_COUNT: prdata = 32'(r_action_count);
            REG_LEARN_RATE:   prdata = 32'(r_learn_rate);
            REG_DISCOUNT:     prdata = 32'(r_discount);
            REG_EXPLORE_RATE: prdata = 32'(r_explore_rate);
            default:          prdata = '0;
        endcase
    end

    // Columns in use
    logic [CW-1:0] cols;

    always_comb begin
        if (r_action_count == '0) begin
            cols = CW'(1);
        end else if (r_action_count > COUNT_W'(MAX_ACTIONS)) begin
            cols = CW'(MAX_ACTIONS);
        end else begin
            cols = CW'(r_action_count);
        end
    end

    // Valid actions of an incoming select, limited to the columns in use
    logic [MAX_ACTIONS-1:0] in_vmask;
    logic [CW-1:0]          in_cnt;

    always_comb begin
        in_cnt = '0;
        for (int a = 0; a < MAX_ACTIONS; a++) begin
            in_vmask[a] = i_valid_mask[a] && (CW'(a) < cols);
            in_cnt      = in_cnt + CW'(in_vmask[a]);
        end
    end

    // Sequencer and datapath registers
    t_state r_state, n_state, dispatch_state;

    t_op                    r_op;
    logic [SIDX_W-1:0]      r_srow, r_nrow;
    logic [3:0]             r_wstep;
    logic [AW-1:0]          r_act;
    logic signed [DATA_W-1:0] r_reward, r_entry;
    logic [MAX_ACTIONS-1:0] r_vmask;
    logic [CW-1:0]          r_cnt;
    logic                   r_explore;
    logic [DRAW_W-1:0]      r_pick;
    logic [3:0]             r_dstep;
    logic [CW-1:0]          r_rem;
    logic [CW-1:0]          r_col;
    logic                   r_pend;
    logic [AW-1:0]          r_pend_col;
    logic                   r_have;
    logic signed [QW-1:0]   r_best;
    logic [AW-1:0]          r_best_a;
    logic signed [QW-1:0]   r_cur;
    logic                   r_pass;
    logic                   r_sc_neg;
    logic [DW-1:0]          r_sc_mag;
    logic [FRAC_W-1:0]      r_sc_frac;
    logic [DW:0]            r_p_hi;
    logic [FRAC_W-1:0]      r_p_lo;
    logic [DW-1:0]          r_sum;
    logic signed [DW-1:0]   r_target;
    logic [QW-1:0]          r_wr_data;
    logic                   r_do_wr;
    logic [AIDX_W-1:0]      r_res_chosen;
    logic [DATA_W-1:0]      r_res_q;
    logic                   r_res_sat;

    logic                   r_out_valid;
    logic [AIDX_W-1:0]      r_out_chosen;
    logic [DATA_W-1:0]      r_out_q;
    logic                   r_out_sat;

    logic signed [QW-1:0]   r_rd_data;
    logic [QW-1:0]          r_mem [DEPTH];

    logic [SW-1:0]  row_idx, nrow_idx, scan_row;
    logic [ADW-1:0] acc_addr, rd_addr;
    logic           scan_issue, scan_done, out_free;
    logic           in_ready, mem_re, mem_we, load_out;

    assign row_idx    = SW'(r_srow);
    assign nrow_idx   = SW'(r_nrow);
    assign scan_row   = (r_op == OP_LEARN) ? nrow_idx : row_idx;
    assign acc_addr   = {row_idx, r_act};
    assign scan_issue = r_col < cols;
    assign scan_done  = !scan_issue && !r_pend;
    assign out_free   = !r_out_valid || i_out_ready;

    always_comb begin
        case (r_op)
            OP_WRITE: dispatch_state = S_WR;
            OP_READ:  dispatch_state = S_RDRD;
            OP_LEARN: dispatch_state = S_SCAN;
            default: begin
                if (r_cnt == '0) begin
                    dispatch_state = S_DONE;
                end else if (r_explore) begin
                    dispatch_state = S_DIV;
                end else begin
                    dispatch_state = S_SCAN;
                end
            end
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_WRAP;
            S_WRAP:  if (r_wstep == '0) n_state = dispatch_state;
            S_WR:    n_state = S_DONE;
            S_RDRD:  n_state = S_RDCAP;
            S_RDCAP: n_state = S_DONE;
            S_SCAN: begin
                if (scan_done) n_state = (r_op == OP_LEARN) ? S_CURRD : S_DONE;
            end
            S_CURRD: n_state = S_CUR;
            S_CUR:   n_state = S_MUL;
            S_MUL:   n_state = S_SUM;
            S_SUM:   n_state = r_pass ? S_UPD : S_TGT;
            S_TGT:   n_state = S_DIFF;
            S_DIFF:  n_state = S_MUL;
            S_UPD:   n_state = S_DONE;
            S_DIV:   if (r_dstep == 4'd15) n_state = S_PICK;
            S_PICK:  if (r_vmask[r_col[AW-1:0]] && r_rem == '0) n_state = S_DONE;
            S_DONE:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        in_ready = 1'b0;
        mem_re   = 1'b0;
        rd_addr  = acc_addr;
        mem_we   = 1'b0;
        load_out = 1'b0;
        case (r_state)
            S_IDLE:  in_ready = 1'b1;
            S_RDRD:  mem_re = 1'b1;
            S_CURRD: mem_re = 1'b1;
            S_SCAN: begin
                mem_re  = scan_issue;
                rd_addr = {scan_row, r_col[AW-1:0]};
            end
            S_DONE: begin
                load_out = out_free;
                mem_we   = out_free && r_do_wr;
            end
            default: ;
        endcase
    end

    assign o_in_ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Table memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[acc_addr] <= r_wr_data;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Datapath helpers
    logic [31:0]            wrap_lim;
    logic signed [DW-1:0]   best_x, cur_x, rew_x, sum_s, d_pos, d_neg;
    logic signed [UW-1:0]   cur_u, sum_u, upd, entry_u;
    logic [DW:0]            prod_hi;
    logic [32:0]            prod_lo;
    logic [CW:0]            div_tmp;

    assign wrap_lim = 32'(NUM_STATES) << r_wstep;
    assign best_x   = DW'(r_best);
    assign cur_x    = DW'(r_cur);
    assign rew_x    = DW'(r_reward);
    assign sum_s    = signed'(r_sum);
    assign d_pos    = r_target - cur_x;
    assign d_neg    = cur_x - r_target;
    assign cur_u    = UW'(r_cur);
    assign sum_u    = signed'({1'b0, r_sum});
    assign upd      = r_sc_neg ? (cur_u - sum_u) : (cur_u + sum_u);
    assign entry_u  = UW'(r_entry);
    assign prod_hi  = (DW+1)'(r_sc_mag[DW-1:16]) * (DW+1)'(r_sc_frac);
    assign prod_lo  = 33'(r_sc_mag[15:0]) * 33'(r_sc_frac);
    assign div_tmp  = {r_rem, r_pick[DRAW_W-1]};

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    r_op         <= t_op'(i_op);
                    r_srow       <= i_state_index;
                    r_nrow       <= i_next_state_index;
                    r_act        <= wrap_act(i_action_index);
                    r_reward     <= i_reward;
                    r_entry      <= i_entry_value;
                    r_vmask      <= in_vmask;
                    r_cnt        <= in_cnt;
                    r_explore    <= {1'b0, i_explore_draw} < r_explore_rate;
                    r_pick       <= i_pick_draw;
                    r_wstep      <= WRAP_START;
                    r_dstep      <= '0;
                    r_rem        <= '0;
                    r_col        <= '0;
                    r_pend       <= 1'b0;
                    r_have       <= 1'b0;
                    r_do_wr      <= 1'b0;
                    r_res_chosen <= '0;
                    r_res_q      <= '0;
                    r_res_sat    <= 1'b0;
                end
            end
            S_WRAP: begin
                // restoring reduction of both row indexes by the table height
                if ({22'b0, r_srow} >= wrap_lim) r_srow <= r_srow - SIDX_W'(wrap_lim);
                if ({22'b0, r_nrow} >= wrap_lim) r_nrow <= r_nrow - SIDX_W'(wrap_lim);
                if (r_wstep != '0) r_wstep <= r_wstep - 4'd1;
            end
            S_WR: begin
                r_wr_data <= clip_q(entry_u);
                r_do_wr   <= 1'b1;
            end
            S_RDCAP: begin
                r_res_q <= to_out(r_rd_data);
            end
            S_SCAN: begin
                if (scan_issue) r_col <= r_col + CW'(1);
                r_pend     <= scan_issue;
                r_pend_col <= r_col[AW-1:0];
                if (r_pend && (r_op == OP_LEARN || r_vmask[r_pend_col])) begin
                    if (!r_have || r_rd_data > r_best) begin
                        r_best   <= r_rd_data;
                        r_best_a <= r_pend_col;
                        r_have   <= 1'b1;
                    end
                end
                if (scan_done && r_op == OP_SELECT) r_res_chosen <= AIDX_W'(r_best_a);
            end
            S_CUR: begin
                r_cur     <= r_rd_data;
                r_sc_neg  <= r_best < 0;
                r_sc_mag  <= (r_best < 0) ? DW'(-best_x) : DW'(best_x);
                r_sc_frac <= clamp_frac(r_discount);
                r_pass    <= 1'b0;
            end
            S_MUL: begin
                r_p_hi <= prod_hi;
                r_p_lo <= prod_lo[32:16];
            end
            S_SUM: begin
                r_sum <= DW'(r_p_hi + (DW+1)'(r_p_lo));
            end
            S_TGT: begin
                r_target <= r_sc_neg ? (rew_x - sum_s) : (rew_x + sum_s);
            end
            S_DIFF: begin
                r_sc_neg  <= r_target < cur_x;
                r_sc_mag  <= (r_target < cur_x) ? DW'(d_neg) : DW'(d_pos);
                r_sc_frac <= clamp_frac(r_learn_rate);
                r_pass    <= 1'b1;
            end
            S_UPD: begin
                r_wr_data <= clip_q(upd);
                r_res_q   <= to_out(signed'(clip_q(upd)));
                r_res_sat <= (upd > Q_HI) || (upd < Q_LO);
                r_do_wr   <= 1'b1;
            end
            S_DIV: begin
                // one remainder bit per cycle, MSB of the draw first
                if (div_tmp >= {1'b0, r_cnt}) begin
                    r_rem <= CW'(div_tmp - {1'b0, r_cnt});
                end else begin
                    r_rem <= CW'(div_tmp);
                end
                r_pick  <= {r_pick[DRAW_W-2:0], 1'b0};
                r_dstep <= r_dstep + 4'd1;
            end
            S_PICK: begin
                if (r_vmask[r_col[AW-1:0]]) begin
                    if (r_rem == '0) begin
                        r_res_chosen <= AIDX_W'(r_col[AW-1:0]);
                    end else begin
                        r_rem <= r_rem - CW'(1);
                    end
                end
                r_col <= r_col + CW'(1);
            end
            default: ;
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_chosen <= r_res_chosen;
            r_out_q      <= r_res_q;
            r_out_sat    <= r_res_sat;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_chosen_action = r_out_chosen;
    assign o_q_value       = signed'(r_out_q);
    assign o_saturated     = r_out_sat;

    // Checks
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("item taken while another is in flight");

    a_write_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> load_out)
        else $error("table written apart from result delivery");

    a_pick_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PICK) |-> (r_col < cols))
        else $error("explore pick ran past the columns in use");

    a_sat_only_learn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load_out && r_res_sat) |-> (r_do_wr && r_op == OP_LEARN))
        else $error("saturation flagged outside a learn update");

endmodule

// ===== sim/q_table_learn_select_checker.sv =====
// Checker for the Q-table engine: mirrors the table, predicts each result beat and compares.
`timescale 1ns / 1ps

module q_table_learn_select_checker
    import qtls_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,

    input  logic                     i_in_valid,
    input  logic                     i_in_ready,
    input  logic [OP_W-1:0]          i_op,
    input  logic [SIDX_W-1:0]        i_state_index,
    input  logic [SIDX_W-1:0]        i_next_state_index,
    input  logic [AIDX_W-1:0]        i_action_index,
    input  logic signed [DATA_W-1:0] i_reward,
    input  logic signed [DATA_W-1:0] i_entry_value,
    input  logic [DATA_W-1:0]        i_valid_mask,
    input  logic [DRAW_W-1:0]        i_explore_draw,
    input  logic [DRAW_W-1:0]        i_pick_draw,

    input  logic                     i_out_valid,
    input  logic                     i_out_ready,
    input  logic [AIDX_W-1:0]        i_chosen_action,
    input  logic signed [DATA_W-1:0] i_q_value,
    input  logic                     i_saturated,

    input  logic                     i_psel,
    input  logic                     i_penable,
    input  logic                     i_pwrite,
    input  logic [3:0]               i_paddr,
    input  logic [31:0]              i_pwdata,
    input  logic                     i_pready,

    output int                       o_pending,
    output int                       o_fail_count
);

    localparam int     ROWS = NUM_STATES_DEF;
    localparam int     COLS = MAX_ACTIONS_DEF;
    localparam longint Q_HI = (longint'(1) <<< (Q_WIDTH_DEF - 1)) - 1;
    localparam longint Q_LO = -Q_HI - 1;

    typedef struct packed {
        logic [AIDX_W-1:0] action;
        logic [DATA_W-1:0] value;
        logic              sat;
    } t_result;

    longint             q_mirror [ROWS*COLS];
    logic [COUNT_W-1:0] action_count;
    logic [FRAC_W-1:0]  learn_rate;
    logic [FRAC_W-1:0]  discount;
    logic [FRAC_W-1:0]  explore_rate;
    t_result            expected_results [$];
    int                 pending_total = 0;
    int                 fail_total = 0;

    assign o_pending    = pending_total;
    assign o_fail_count = fail_total;

    // v * f / 65536 with f capped at one, truncated toward zero
    function automatic longint scale_by_fraction(longint v, logic [FRAC_W-1:0] f);
        longint unsigned mag;
        longint unsigned fr;
        longint unsigned prod;
        fr   = (f > FRAC_ONE) ? FRAC_ONE : f;
        mag  = (v < 0) ? -v : v;
        prod = (mag >> 16) * fr + (((mag & 64'hFFFF) * fr) >> 16);
        return (v < 0) ? -longint'(prod) : longint'(prod);
    endfunction

    function automatic int columns_in_use();
        if (action_count == 0) return 1;
        if (action_count > COLS) return COLS;
        return int'(action_count);
    endfunction

    function automatic t_result apply_request(
        t_op                     op,
        logic [SIDX_W-1:0]       s,
        logic [SIDX_W-1:0]       ns,
        logic [AIDX_W-1:0]       a,
        logic signed [DATA_W-1:0] reward,
        logic signed [DATA_W-1:0] entry,
        logic [DATA_W-1:0]       mask,
        logic [DRAW_W-1:0]       edraw,
        logic [DRAW_W-1:0]       pdraw
    );
        t_result res;
        int      base;
        int      nbase;
        int      slot;
        int      cols;
        int      n;
        int      picks [COLS];
        int      best_a;
        longint  best;
        longint  cur;
        longint  target;
        longint  upd;
        res   = '0;
        base  = (int'(s) % ROWS) * COLS;
        nbase = (int'(ns) % ROWS) * COLS;
        slot  = base + int'(a) % COLS;
        cols  = columns_in_use();
        case (op)
            OP_WRITE: begin
                upd = longint'(entry);
                if (upd > Q_HI) upd = Q_HI;
                if (upd < Q_LO) upd = Q_LO;
                q_mirror[slot] = upd;
            end
            OP_READ: begin
                res.value = DATA_W'(q_mirror[slot]);
            end
            OP_LEARN: begin
                // next row is scanned before the entry changes, even on the same row
                best = q_mirror[nbase];
                for (int c = 1; c < cols; c++)
                    if (q_mirror[nbase + c] > best) best = q_mirror[nbase + c];
                cur    = q_mirror[slot];
                target = longint'(reward) + scale_by_fraction(best, discount);
                upd    = cur + scale_by_fraction(target - cur, learn_rate);
                if (upd > Q_HI) begin
                    upd = Q_HI;
                    res.sat = 1'b1;
                end else if (upd < Q_LO) begin
                    upd = Q_LO;
                    res.sat = 1'b1;
                end
                q_mirror[slot] = upd;
                res.value = DATA_W'(upd);
            end
            default: begin
                n = 0;
                for (int c = 0; c < cols; c++)
                    if (mask[c]) begin
                        picks[n] = c;
                        n++;
                    end
                if (n != 0) begin
                    if ({1'b0, edraw} < explore_rate) begin
                        res.action = AIDX_W'(picks[int'(pdraw) % n]);
                    end else begin
                        // first valid action with the strictly highest value
                        best_a = picks[0];
                        best   = q_mirror[base + picks[0]];
                        for (int i = 1; i < n; i++)
                            if (q_mirror[base + picks[i]] > best) begin
                                best   = q_mirror[base + picks[i]];
                                best_a = picks[i];
                            end
                        res.action = AIDX_W'(best_a);
                    end
                end
            end
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            action_count = ACTION_COUNT_RST;
            learn_rate   = LEARN_RATE_RST;
            discount     = DISCOUNT_RST;
            explore_rate = EXPLORE_RATE_RST;
            expected_results.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[3:2])
                    REG_ACTION_COUNT: action_count = i_pwdata[COUNT_W-1:0];
                    REG_LEARN_RATE:   learn_rate   = i_pwdata[FRAC_W-1:0];
                    REG_DISCOUNT:     discount     = i_pwdata[FRAC_W-1:0];
                    REG_EXPLORE_RATE: explore_rate = i_pwdata[FRAC_W-1:0];
                    default: ;
                endcase
            end
            // retire the result beat before taking a new request beat
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result beat with no request outstanding: action %0d value 0x%08h",
                           i_chosen_action, i_q_value);
                    fail_total++;
                end else begin
                    want = expected_results.pop_front();
                    if (i_chosen_action !== want.action) begin
                        $error("chosen_action: expected %0d, actual %0d",
                               want.action, i_chosen_action);
                        fail_total++;
                    end
                    if (i_q_value !== want.value) begin
                        $error("q_value: expected 0x%08h, actual 0x%08h", want.value, i_q_value);
                        fail_total++;
                    end
                    if (i_saturated !== want.sat) begin
                        $error("saturated: expected %0b, actual %0b", want.sat, i_saturated);
                        fail_total++;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                expected_results.push_back(apply_request(t_op'(i_op), i_state_index,
                    i_next_state_index, i_action_index, i_reward, i_entry_value,
                    i_valid_mask, i_explore_draw, i_pick_draw));
        end
        pending_total = expected_results.size();
    end

endmodule

// ===== sim/tb_q_table_learn_select_engine.sv =====
// Testbench top for the Q-table engine: clock, reset, request and register stimulus, verdict.
`timescale 1ns / 1ps

module tb_q_table_learn_select_engine;
    import qtls_pkg::*;

    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 204;
    localparam int LIVE_ROWS       = 8;
    localparam int RESET_CYCLES    = 6;
    localparam int STALL_LIMIT     = 4000;
    localparam int SETTLE_CYCLES   = 64;
    localparam int IDLE_PERCENT    = 31;

    localparam logic [DATA_W-1:0] Q_POS_MAX   = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] Q_NEG_MAX   = 32'h8000_0000;
    localparam logic [DATA_W-1:0] ALL_ACTIONS = 32'hFFFF_FFFF;
    localparam logic [DATA_W-1:0] ONE_Q       = 32'h0001_0000;

    typedef struct {
        t_op               op;
        logic [SIDX_W-1:0] state;
        logic [SIDX_W-1:0] follow_row;
        logic [AIDX_W-1:0] action;
        logic [DATA_W-1:0] reward;
        logic [DATA_W-1:0] entry;
        logic [DATA_W-1:0] mask;
        logic [DRAW_W-1:0] edraw;
        logic [DRAW_W-1:0] pdraw;
    } t_request;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_ready;
    logic [OP_W-1:0]          i_op = '0;
    logic [SIDX_W-1:0]        i_state_index = '0;
    logic [SIDX_W-1:0]        i_next_state_index = '0;
    logic [AIDX_W-1:0]        i_action_index = '0;
    logic signed [DATA_W-1:0] i_reward = '0;
    logic signed [DATA_W-1:0] i_entry_value = '0;
    logic [DATA_W-1:0]        i_valid_mask = '0;
    logic [DRAW_W-1:0]        i_explore_draw = '0;
    logic [DRAW_W-1:0]        i_pick_draw = '0;
    logic                     o_out_valid;
    logic                     i_out_ready = 1'b0;
    logic [AIDX_W-1:0]        o_chosen_action;
    logic signed [DATA_W-1:0] o_q_value;
    logic                     o_saturated;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [3:0]               paddr = '0;
    logic [31:0]              pwdata = '0;
    logic [31:0]              prdata;
    logic                     pready;

    int                       pending_total;
    int                       fail_total;
    int                       stall_cycles = 0;
    logic                     no_idle = 1'b0;
    logic [SIDX_W-1:0]        live_rows [LIVE_ROWS];

    q_table_learn_select_engine dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_op               (i_op),
        .i_state_index      (i_state_index),
        .i_next_state_index (i_next_state_index),
        .i_action_index     (i_action_index),
        .i_reward           (i_reward),
        .i_entry_value      (i_entry_value),
        .i_valid_mask       (i_valid_mask),
        .i_explore_draw     (i_explore_draw),
        .i_pick_draw        (i_pick_draw),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_chosen_action    (o_chosen_action),
        .o_q_value          (o_q_value),
        .o_saturated        (o_saturated),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    q_table_learn_select_checker u_learn_select_check (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .i_in_ready         (o_in_ready),
        .i_op               (i_op),
        .i_state_index      (i_state_index),
        .i_next_state_index (i_next_state_index),
        .i_action_index     (i_action_index),
        .i_reward           (i_reward),
        .i_entry_value      (i_entry_value),
        .i_valid_mask       (i_valid_mask),
        .i_explore_draw     (i_explore_draw),
        .i_pick_draw        (i_pick_draw),
        .i_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .i_chosen_action    (o_chosen_action),
        .i_q_value          (o_q_value),
        .i_saturated        (o_saturated),
        .i_psel             (psel),
        .i_penable          (penable),
        .i_pwrite           (pwrite),
        .i_paddr            (paddr),
        .i_pwdata           (pwdata),
        .i_pready           (pready),
        .o_pending          (pending_total),
        .o_fail_count       (fail_total)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(negedge i_clk)
        i_out_ready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);

    // end the run when neither channel moves a beat for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(9))
            0:       return Q_POS_MAX;
            1:       return Q_NEG_MAX;
            2, 3:    return DATA_W'((int'($urandom_range(4)) - 2) * 65536);
            4, 5, 6: return DATA_W'(int'($urandom_range(2097152)) - 1048576);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_request make_request(t_op op, int s, int ns, int a,
                                              logic [DATA_W-1:0] reward,
                                              logic [DATA_W-1:0] entry,
                                              logic [DATA_W-1:0] mask, int ed, int pd);
        t_request r;
        r.op         = op;
        r.state      = SIDX_W'(s);
        r.follow_row = SIDX_W'(ns);
        r.action     = AIDX_W'(a);
        r.reward     = reward;
        r.entry      = entry;
        r.mask       = mask;
        r.edraw      = DRAW_W'(ed);
        r.pdraw      = DRAW_W'(pd);
        return r;
    endfunction

    // reads, learns and selects stay on fully written rows
    function automatic t_request random_request();
        t_request r;
        int       roll;
        roll = $urandom_range(99);
        if (roll < 25)      r.op = OP_WRITE;
        else if (roll < 45) r.op = OP_READ;
        else if (roll < 75) r.op = OP_LEARN;
        else                r.op = OP_SELECT;
        r.state = live_rows[$urandom_range(LIVE_ROWS - 1)];
        if (r.op == OP_WRITE && $urandom_range(4) == 0)
            r.state = SIDX_W'($urandom);
        r.follow_row = live_rows[$urandom_range(LIVE_ROWS - 1)];
        r.action     = AIDX_W'($urandom);
        r.reward     = pick_value();
        r.entry      = pick_value();
        case ($urandom_range(9))
            0:       r.mask = '0;
            1, 2:    r.mask = DATA_W'(1) << $urandom_range(31);
            3, 4:    r.mask = ALL_ACTIONS;
            default: r.mask = $urandom;
        endcase
        case ($urandom_range(3))
            0:       r.edraw = '0;
            1:       r.edraw = '1;
            default: r.edraw = DRAW_W'($urandom);
        endcase
        r.pdraw = ($urandom_range(7) == 0) ? DRAW_W'(-1) : DRAW_W'($urandom);
        return r;
    endfunction

    task automatic send_request(input t_request r);
        @(negedge i_clk);
        while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_op               <= r.op;
        i_state_index      <= r.state;
        i_next_state_index <= r.follow_row;
        i_action_index     <= r.action;
        i_reward           <= r.reward;
        i_entry_value      <= r.entry;
        i_valid_mask       <= r.mask;
        i_explore_draw     <= r.edraw;
        i_pick_draw        <= r.pdraw;
        i_in_valid         <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // drop valid and hold until every predicted result beat has come back
    task automatic wait_until_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_total != 0) @(negedge i_clk);
    endtask

    task automatic program_register(input logic [1:0] index, input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // fill bits above the register width with noise half the time
    function automatic logic [31:0] with_noise(int value, int width);
        logic [31:0] upper;
        upper = ($urandom_range(1) != 0) ? ($urandom & ~((32'd1 << width) - 1)) : '0;
        return upper | 32'(value);
    endfunction

    task automatic apply_tuning(input int count, input int alpha, input int gamma,
                                input int epsilon);
        program_register(REG_ACTION_COUNT, with_noise(count, COUNT_W));
        program_register(REG_LEARN_RATE, with_noise(alpha, FRAC_W));
        program_register(REG_DISCOUNT, with_noise(gamma, FRAC_W));
        program_register(REG_EXPLORE_RATE, with_noise(epsilon, FRAC_W));
    endtask

    initial begin
        live_rows[0] = '0;
        live_rows[1] = SIDX_W'(1023);
        live_rows[2] = SIDX_W'('h155);
        live_rows[3] = SIDX_W'('h2AA);
        for (int i = 4; i < LIVE_ROWS; i++)
            live_rows[i] = SIDX_W'($urandom_range(1022, 1));

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase > 0) wait_until_drained();
            case (phase)
                0: begin
                    // every column of the live rows, one row all negative
                    for (int i = 0; i < LIVE_ROWS; i++)
                        for (int c = 0; c < MAX_ACTIONS_DEF; c++)
                            send_request(make_request(OP_WRITE, live_rows[i], $urandom, c,
                                $urandom,
                                (live_rows[i] == 'h2AA) ?
                                    DATA_W'(-int'($urandom_range(1 << 30, 1))) : pick_value(),
                                $urandom, $urandom, $urandom));
                    send_request(make_request(OP_WRITE, 0, 0, 0, 0, Q_POS_MAX, 0, 0, 0));
                    send_request(make_request(OP_WRITE, 0, 0, 31, 0, Q_NEG_MAX, 0, 0, 0));
                    send_request(make_request(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0));
                    send_request(make_request(OP_READ, 0, 0, 31, 0, 0, 0, 0, 0));
                    send_request(make_request(OP_READ, 1023, 1023, 31, 0, 0, 0, 0, 0));
                    send_request(make_request(OP_LEARN, 'h155, 0, 3, Q_POS_MAX, 0, 0, 0, 0));
                    send_request(make_request(OP_LEARN, 1023, 'h2AA, 31, Q_NEG_MAX, 0, 0, 0, 0));
                    send_request(make_request(OP_LEARN, 'h155, 'h155, 0, ONE_Q, 0, 0, 0, 0));
                    send_request(make_request(OP_SELECT, 0, 0, 0, 0, 0, 0, 'hFFFF, 0));
                    send_request(make_request(OP_SELECT, 0, 0, 0, 0, 0, ALL_ACTIONS, 0, 'hFFFF));
                    send_request(make_request(OP_SELECT, 0, 0, 0, 0, 0, ALL_ACTIONS, 'hFFFF, 0));
                    // explore threshold, just below and at epsilon
                    send_request(make_request(OP_SELECT, 'h2AA, 0, 0, 0, 0, 32'h8000_0001,
                                              6553, 7));
                    send_request(make_request(OP_SELECT, 'h2AA, 0, 0, 0, 0, 32'h8000_0001,
                                              6554, 7));
                end
                1: begin
                    apply_tuning(32, 65536, 65536, 0);
                    send_request(make_request(OP_LEARN, 'h155, 0, 1, Q_POS_MAX, 0, 0, 0, 0));
                    send_request(make_request(OP_LEARN, 'h155, 'h2AA, 2, Q_NEG_MAX, 0, 0, 0, 0));
                    send_request(make_request(OP_READ, 'h155, 0, 2, 0, 0, 0, 0, 0));
                    // tie on the highest value: first one wins
                    send_request(make_request(OP_WRITE, 1023, 0, 4, 0, Q_POS_MAX, 0, 0, 0));
                    send_request(make_request(OP_WRITE, 1023, 0, 9, 0, Q_POS_MAX, 0, 0, 0));
                    send_request(make_request(OP_SELECT, 1023, 0, 0, 0, 0, 32'h0000_0210,
                                              'hFFFF, 0));
                end
                2: begin
                    apply_tuning(1, 0, 0, 65536);
                    send_request(make_request(OP_SELECT, 0, 0, 0, 0, 0, 32'hFFFF_FFFE, 0, 0));
                    send_request(make_request(OP_SELECT, 0, 0, 0, 0, 0, ALL_ACTIONS, 0, 'hFFFF));
                end
                3: apply_tuning(0, 'h1FFFF, 'h1FFFF, 'h1FFFF);
                4: apply_tuning(63, 32768, 49152, 32768);
                5: apply_tuning(17, $urandom_range(65536), $urandom_range(65536),
                                $urandom_range(65536));
                6: apply_tuning($urandom_range(63), $urandom_range('h1FFFF),
                                $urandom_range('h1FFFF), $urandom_range('h1FFFF));
                default: apply_tuning(5, 1, 65535, 65535);
            endcase
            no_idle = (phase == 4);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if ($urandom_range(99) < 2) wait_until_drained();
                send_request(random_request());
            end
        end

        wait_until_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (fail_total == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
